// ----- design/bbt_pkg.sv -----
// Shared types and constants for the Bollinger band tracker.
// Used by the controller, the datapath and the top level.
`default_nettype none
package bbt_pkg;

  localparam int PRICE_W = 24;
  localparam int LEN_CFG_W = 6;
  localparam int K_W = 10;
  localparam int CFG_W = 10;
  localparam int KD_W = 26;
  localparam int WIDTH_W = KD_W + 1;
  localparam int UPPER_W = 26;
  localparam int LOWER_W = 27;
  localparam int PB_W = 17;
  localparam int RELW_W = 20;
  localparam int PB_FRAC_W = 16;

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_BAND_MULTIPLIER = 1'b1;

  localparam logic [LEN_CFG_W-1:0] WINDOW_LENGTH_RESET = 6'd20;
  localparam logic [K_W-1:0] BAND_MULTIPLIER_RESET = 10'd512;

  localparam logic [PB_W-1:0] PB_ZERO = 17'd0;
  localparam logic [PB_W-1:0] PB_HALF = 17'd32768;
  localparam logic [PB_W-1:0] PB_ONE = 17'd65536;
  localparam logic [RELW_W-1:0] RELW_MAX = 20'hFFFFF;
  localparam logic [UPPER_W-1:0] UPPER_MAX = 26'h3FFFFFF;
  localparam logic signed [LOWER_W-1:0] LOWER_MIN = 27'sh4000000;

  typedef enum logic [1:0] {
    PB_SEL_HALF,
    PB_SEL_ZERO,
    PB_SEL_ONE,
    PB_SEL_DIV
  } bbt_pb_sel_t;

  typedef enum logic [1:0] {
    RW_SEL_ZERO,
    RW_SEL_MAX,
    RW_SEL_DIV
  } bbt_rw_sel_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic accum;
    logic product;
    logic diff;
    logic div_a_start;
    logic root_start;
    logic scale;
    logic bands;
    logic load;
  } bbt_cmd_t;

  typedef struct packed {
    logic full;
    logic div_a_done;
    logic root_done;
    logic div_b_done;
  } bbt_status_t;

endpackage
`default_nettype wire

// ----- design/bollinger_band_tracker_core.sv -----
// Top level of the Bollinger band tracker: controller plus datapath.
// Depends on bbt_pkg, bbt_ctrl and bbt_datapath.
//
// One closing price is taken per item and yields one result item. Until the
// window holds window_length prices (clamped to 2..WINDOW_DEPTH) the result
// has ready_res low and all fields zero. The next item is taken only once the
// result of the previous one is loaded into the output register. The serial
// variance divider (one bit a cycle over twice the price width), the serial
// square root and the percent-B and bandwidth dividers set most of the time
// for a full window; the rest is bookkeeping and handover. A result that is
// not taken stalls the sequencer before its output register is reloaded. A
// finished result waits in the output register while the next item is
// accepted. Writing window_length clears the window.
`default_nettype none
module bollinger_band_tracker_core
  import bbt_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32,
  parameter int PRICE_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PRICE_W-1:0]   close_price,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      ready_res,
  output logic [PRICE_W-1:0]        band_mean,
  output logic [PRICE_W-1:0]        band_deviation,
  output logic [UPPER_W-1:0]        upper_band,
  output logic signed [LOWER_W-1:0] lower_band,
  output logic [PB_W-1:0]           pct_b,
  output logic [RELW_W-1:0]         relative_width
);

  bbt_cmd_t    cmd;
  bbt_status_t status;

  bbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bbt_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PRICE_BITS   (PRICE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .close_price    (close_price),
    .cmd            (cmd),
    .status         (status),
    .ready_res      (ready_res),
    .band_mean      (band_mean),
    .band_deviation (band_deviation),
    .upper_band     (upper_band),
    .lower_band     (lower_band),
    .pct_b          (pct_b),
    .relative_width (relative_width)
  );

endmodule
`default_nettype wire

// ----- design/bbt_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
// The caller preloads a partial remainder below the divisor; no package needed.
`default_nettype none
module bbt_div #(
  parameter int QW = 16,
  parameter int RW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [RW-1:0] rem_init,
  input  wire logic [QW-1:0] low_in,
  input  wire logic [RW-1:0] divisor,
  output logic               done,
  output logic [QW-1:0]      quot
);

  localparam int CW = $clog2(QW + 1);

  logic [RW-1:0] rem;
  logic [CW-1:0] count;
  logic          busy;
  logic [RW:0]   trial;
  logic          ge;

  assign trial = {rem, quot[QW-1]};
  assign ge = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rem <= rem_init;
      quot <= low_in;
      count <= CW'(QW);
    end else if (busy) begin
      rem <= ge ? RW'(trial - {1'b0, divisor}) : RW'(trial);
      quot <= {quot[QW-2:0], ge};
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/bbt_sqrt.sv -----
// Serial integer square root, one result bit per cycle.
// Self-contained; no package needed.
`default_nettype none
module bbt_sqrt #(
  parameter int RW = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] radicand,
  output logic                 done,
  output logic [RW-1:0]        root
);

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] x;
  logic [RW:0]     rem;
  logic [CW-1:0]   count;
  logic            busy;
  logic [RW+2:0]   t;
  logic [RW+2:0]   trial;
  logic            ge;

  assign t = {rem, x[2*RW-1:2*RW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      x <= radicand;
      rem <= '0;
      root <= '0;
      count <= CW'(RW);
    end else if (busy) begin
      rem <= ge ? (RW+1)'(t - trial) : (RW+1)'(t);
      root <= {root[RW-2:0], ge};
      x <= {x[2*RW-3:0], 2'b00};
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/bbt_ctrl.sv -----
// Sequencer for the Bollinger band tracker.
// Depends on bbt_pkg for the command and status structs.
`default_nettype none
module bbt_ctrl
  import bbt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire bbt_status_t status,
  output bbt_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_CHECK,
    S_DIFF,
    S_DIV_A,
    S_DIV_A_WAIT,
    S_ROOT_WAIT,
    S_SCALE,
    S_BANDS,
    S_DIV_B_WAIT,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.square = (state == S_SQUARE);
    cmd.accum = (state == S_ACCUM);
    cmd.product = (state == S_CHECK);
    cmd.diff = (state == S_DIFF);
    cmd.div_a_start = (state == S_DIV_A);
    cmd.root_start = (state == S_DIV_A_WAIT) && status.div_a_done;
    cmd.scale = (state == S_SCALE);
    cmd.bands = (state == S_BANDS);
    cmd.load = (state == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM: state <= S_CHECK;
        S_CHECK: begin
          state <= status.full ? S_DIFF : S_OUT;
        end
        S_DIFF: state <= S_DIV_A;
        S_DIV_A: state <= S_DIV_A_WAIT;
        S_DIV_A_WAIT: begin
          if (status.div_a_done) begin
            state <= S_ROOT_WAIT;
          end
        end
        S_ROOT_WAIT: begin
          if (status.root_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_BANDS;
        S_BANDS: state <= S_DIV_B_WAIT;
        S_DIV_B_WAIT: begin
          if (status.div_b_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/bbt_datapath.sv -----
// Datapath of the Bollinger band tracker: price ring, running sums, dividers,
// square root, band arithmetic and the result register. Depends on bbt_pkg.
`default_nettype none
module bbt_datapath
  import bbt_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32,
  parameter int PRICE_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write_en,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data,
  input  wire logic [PRICE_W-1:0]        close_price,
  input  wire bbt_cmd_t                  cmd,
  output bbt_status_t                    status,
  output logic                           ready_res,
  output logic [PRICE_W-1:0]             band_mean,
  output logic [PRICE_W-1:0]             band_deviation,
  output logic [UPPER_W-1:0]             upper_band,
  output logic signed [LOWER_W-1:0]      lower_band,
  output logic [PB_W-1:0]                pct_b,
  output logic [RELW_W-1:0]              relative_width
);

  localparam int SW = $clog2(WINDOW_DEPTH);
  localparam int LW = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = PRICE_W + LW;
  localparam int SQ_W = 2 * PRICE_W + LW;
  localparam int VW = 2 * PRICE_W + 2 * LW;
  localparam int SIGNED_W = KD_W + 2;
  localparam logic [PRICE_W-1:0] PRICE_MASK = (PRICE_BITS >= PRICE_W) ?
      {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);

  logic [LEN_CFG_W-1:0]     window_length;
  logic [K_W-1:0]           band_multiplier;
  logic [LW-1:0]            eff_len;

  logic [PRICE_W-1:0]       ring [WINDOW_DEPTH];
  logic [PRICE_W-1:0]       ring_q;
  logic [SW-1:0]            write_slot;
  logic [SW-1:0]            slot_cur;
  logic [SW-1:0]            slot_r;
  logic [LW-1:0]            fill_count;
  logic [SUM_W-1:0]         window_sum;
  logic [SQ_W-1:0]          window_square_sum;
  logic                     full_before;

  logic [PRICE_W-1:0]       price_r;
  logic [2*PRICE_W-1:0]     price_sq;
  logic [2*PRICE_W-1:0]     old_sq;
  logic [VW-1:0]            len_sumsq;
  logic [VW-1:0]            sum_sq;
  logic [2*LW-1:0]          len_sq;
  logic [VW-1:0]            var_num;

  logic                     mean_done;
  logic [PRICE_W-1:0]       mean_q;
  logic                     var_done;
  logic [2*PRICE_W-1:0]     var_q;
  logic [PRICE_W-1:0]       root;

  logic [PRICE_W-1:0]       mean_r;
  logic [PRICE_W-1:0]       sd_r;
  logic [KD_W-1:0]          kd;
  logic [K_W+PRICE_W-1:0]   k_sd;

  logic [WIDTH_W-1:0]       band_w;
  logic [WIDTH_W-1:0]       upper_full;
  logic signed [SIGNED_W-1:0] lower_full;
  logic signed [SIGNED_W-1:0] above;
  logic [WIDTH_W:0]         mean_x16;
  logic [UPPER_W-1:0]       upper_r;
  logic signed [LOWER_W-1:0] lower_r;
  bbt_pb_sel_t              pb_sel;
  bbt_rw_sel_t              rw_sel;
  logic                     pb_done;
  logic [PB_FRAC_W-1:0]     pb_q;
  logic                     rw_done;
  logic [RELW_W-1:0]        rw_q;

  always_comb begin
    if (window_length < LEN_CFG_W'(2)) begin
      eff_len = LW'(2);
    end else if (32'(window_length) > WINDOW_DEPTH) begin
      eff_len = LW'(WINDOW_DEPTH);
    end else begin
      eff_len = LW'(window_length);
    end
  end

  assign slot_cur = (32'(write_slot) >= 32'(eff_len)) ? '0 : write_slot;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ring_q <= ring[slot_cur];
    end
    if (cmd.accum) begin
      ring[slot_r] <= price_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      band_multiplier <= BAND_MULTIPLIER_RESET;
      write_slot <= '0;
      fill_count <= '0;
      window_sum <= '0;
      window_square_sum <= '0;
    end else if (cfg_write_en) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data[LEN_CFG_W-1:0];
        write_slot <= '0;
        fill_count <= '0;
        window_sum <= '0;
        window_square_sum <= '0;
      end else begin
        band_multiplier <= cfg_data[K_W-1:0];
      end
    end else if (cmd.accum) begin
      window_sum <= window_sum - (full_before ? SUM_W'(ring_q) : '0) + SUM_W'(price_r);
      window_square_sum <= window_square_sum - (full_before ? SQ_W'(old_sq) : '0)
                           + SQ_W'(price_sq);
      if (!full_before) begin
        fill_count <= fill_count + LW'(1);
      end
      write_slot <= (32'(slot_r) + 32'd1 >= 32'(eff_len)) ? '0 : slot_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      price_r <= close_price & PRICE_MASK;
      slot_r <= slot_cur;
      full_before <= fill_count >= eff_len;
    end
    if (cmd.square) begin
      price_sq <= price_r * price_r;
      old_sq <= ring_q * ring_q;
    end
    if (cmd.product) begin
      len_sumsq <= VW'(eff_len) * VW'(window_square_sum);
      sum_sq <= VW'(window_sum) * VW'(window_sum);
      len_sq <= (2*LW)'(eff_len) * (2*LW)'(eff_len);
    end
    if (cmd.diff) begin
      var_num <= len_sumsq - sum_sq;
    end
    if (cmd.scale) begin
      mean_r <= mean_q;
      sd_r <= root;
      kd <= k_sd[K_W+PRICE_W-1:8];
    end
  end

  assign k_sd = (K_W+PRICE_W)'(band_multiplier) * (K_W+PRICE_W)'(root);

  assign status.full = fill_count >= eff_len;
  assign status.div_a_done = mean_done && var_done;

  bbt_div #(.QW(PRICE_W), .RW(LW)) u_mean_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_a_start),
    .rem_init (LW'(window_sum >> PRICE_W)),
    .low_in   (window_sum[PRICE_W-1:0]),
    .divisor  (eff_len),
    .done     (mean_done),
    .quot     (mean_q)
  );

  bbt_div #(.QW(2*PRICE_W), .RW(2*LW)) u_var_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_a_start),
    .rem_init (var_num[VW-1:2*PRICE_W]),
    .low_in   (var_num[2*PRICE_W-1:0]),
    .divisor  (len_sq),
    .done     (var_done),
    .quot     (var_q)
  );

  bbt_sqrt #(.RW(PRICE_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (var_q),
    .done     (status.root_done),
    .root     (root)
  );

  assign band_w = {kd, 1'b0};
  assign upper_full = WIDTH_W'(mean_r) + WIDTH_W'(kd);
  assign lower_full = $signed(SIGNED_W'(mean_r)) - $signed(SIGNED_W'(kd));
  assign above = $signed(SIGNED_W'(price_r)) - lower_full;
  assign mean_x16 = {mean_r, 4'b0000};

  always_ff @(posedge clk) begin
    if (cmd.bands) begin
      upper_r <= upper_full[WIDTH_W-1] ? UPPER_MAX : upper_full[UPPER_W-1:0];
      lower_r <= (lower_full < $signed(SIGNED_W'(LOWER_MIN))) ? LOWER_MIN
                 : lower_full[LOWER_W-1:0];
      if (band_w == '0) begin
        pb_sel <= PB_SEL_HALF;
      end else if (above <= 0) begin
        pb_sel <= PB_SEL_ZERO;
      end else if (above >= $signed(SIGNED_W'(band_w))) begin
        pb_sel <= PB_SEL_ONE;
      end else begin
        pb_sel <= PB_SEL_DIV;
      end
      if (mean_r == '0) begin
        rw_sel <= RW_SEL_ZERO;
      end else if ({1'b0, band_w} >= mean_x16) begin
        rw_sel <= RW_SEL_MAX;
      end else begin
        rw_sel <= RW_SEL_DIV;
      end
    end
  end

  bbt_div #(.QW(PB_FRAC_W), .RW(WIDTH_W)) u_pb_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.bands),
    .rem_init (above[WIDTH_W-1:0]),
    .low_in   ('0),
    .divisor  (band_w),
    .done     (pb_done),
    .quot     (pb_q)
  );

  bbt_div #(.QW(RELW_W), .RW(PRICE_W)) u_rw_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.bands),
    .rem_init (PRICE_W'(band_w >> 4)),
    .low_in   ({band_w[3:0], 16'h0000}),
    .divisor  (mean_r),
    .done     (rw_done),
    .quot     (rw_q)
  );

  assign status.div_b_done = pb_done && rw_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (status.full) begin
        ready_res <= 1'b1;
        band_mean <= mean_r;
        band_deviation <= sd_r;
        upper_band <= upper_r;
        lower_band <= lower_r;
        case (pb_sel)
          PB_SEL_HALF: pct_b <= PB_HALF;
          PB_SEL_ZERO: pct_b <= PB_ZERO;
          PB_SEL_ONE: pct_b <= PB_ONE;
          default: pct_b <= PB_W'(pb_q);
        endcase
        case (rw_sel)
          RW_SEL_ZERO: relative_width <= '0;
          RW_SEL_MAX: relative_width <= RELW_MAX;
          default: relative_width <= rw_q;
        endcase
      end else begin
        ready_res <= 1'b0;
        band_mean <= '0;
        band_deviation <= '0;
        upper_band <= '0;
        lower_band <= '0;
        pct_b <= '0;
        relative_width <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for bollinger_band_tracker_core: drives closing prices, predicts
// the band statistics of each item and checks every result field. Depends on bbt_pkg.
`timescale 1ns / 100ps
module testbench;
  import bbt_pkg::*;

  typedef struct {
    logic                 rdy;
    logic [PRICE_W-1:0]   mean;
    logic [PRICE_W-1:0]   dev;
    logic [UPPER_W-1:0]   upper;
    logic [LOWER_W-1:0]   lower;
    logic [PB_W-1:0]      pb;
    logic [RELW_W-1:0]    relw;
  } band_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic cfg_index = REG_WINDOW_LENGTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PRICE_W-1:0] close_price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ready_res;
  logic [PRICE_W-1:0] band_mean, band_deviation;
  logic [UPPER_W-1:0] upper_band;
  logic signed [LOWER_W-1:0] lower_band;
  logic [PB_W-1:0] pct_b;
  logic [RELW_W-1:0] relative_width;

  bollinger_band_tracker_core u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("testbench: done, errors");
    $finish;
  end

  // Predictor state.
  logic [5:0]  win_len_cfg = WINDOW_LENGTH_RESET;
  logic [9:0]  k_cfg = BAND_MULTIPLIER_RESET;
  logic [23:0] price_hist [32];
  int unsigned slot_ptr, filled;
  longint unsigned run_sum, run_sq;
  band_result_t pending_bands[$];
  int err_count = 0;
  int send_idle = 0, recv_stall = 0;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_history();
    slot_ptr = 0;
    filled = 0;
    run_sum = 0;
    run_sq = 0;
  endfunction

  function automatic band_result_t predict_bands(logic [23:0] price);
    band_result_t r;
    int unsigned len, s;
    longint unsigned mean, sd, kd, width, vn, pb, relw, p, old;
    longint upper, lower, above;
    len = win_len_cfg < 2 ? 2 : (win_len_cfg > 32 ? 32 : win_len_cfg);
    s = slot_ptr >= len ? 0 : slot_ptr;
    p = 64'(price);
    if (filled >= len) begin
      old = 64'(price_hist[s[4:0]]);
      run_sum -= old;
      run_sq -= old * old;
    end else begin
      filled++;
    end
    price_hist[s[4:0]] = price;
    run_sum += p;
    run_sq += p * p;
    slot_ptr = (s + 1 >= len) ? 0 : s + 1;
    r = '{default: '0};
    if (filled < len) return r;
    mean = run_sum / len;
    vn = longint'(len) * run_sq - run_sum * run_sum;
    sd = isqrt(vn / (longint'(len) * len));
    kd = (longint'(k_cfg) * sd) >> 8;
    width = 2 * kd;
    upper = longint'(mean) + longint'(kd);
    lower = longint'(mean) - longint'(kd);
    if (width == 0) pb = 64'(PB_HALF);
    else begin
      above = longint'(p) - lower;
      if (above <= 0) pb = 0;
      else if (longint'(above) >= longint'(width)) pb = 64'(PB_ONE);
      else pb = (above * 65536) / width;
    end
    if (mean == 0) relw = 0;
    else begin
      relw = (width * 65536) / mean;
      if (relw > RELW_MAX) relw = 64'(RELW_MAX);
    end
    if (upper > longint'(UPPER_MAX)) upper = longint'(UPPER_MAX);
    if (lower < -64'sd67108864) lower = -64'sd67108864;
    r.rdy = 1'b1;
    r.mean = mean[23:0];
    r.dev = sd[23:0];
    r.upper = upper[25:0];
    r.lower = lower[26:0];
    r.pb = pb[16:0];
    r.relw = relw[19:0];
    return r;
  endfunction

  // Receiver: random stall and field-by-field check.
  always @(posedge clk) begin
    band_result_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_bands.size() == 0) begin
          $error("unexpected result item");
          err_count++;
        end else begin
          e = pending_bands.pop_front();
          if (ready_res !== e.rdy) begin
            $error("ready_res exp %0d got %0d", e.rdy, ready_res); err_count++;
          end
          if (band_mean !== e.mean) begin
            $error("band_mean exp %0d got %0d", e.mean, band_mean); err_count++;
          end
          if (band_deviation !== e.dev) begin
            $error("band_deviation exp %0d got %0d", e.dev, band_deviation); err_count++;
          end
          if (upper_band !== e.upper) begin
            $error("upper_band exp %0d got %0d", e.upper, upper_band); err_count++;
          end
          if (lower_band !== e.lower) begin
            $error("lower_band exp %0d got %0d", $signed(e.lower), lower_band);
            err_count++;
          end
          if (pct_b !== e.pb) begin
            $error("pct_b exp %0d got %0d", e.pb, pct_b); err_count++;
          end
          if (relative_width !== e.relw) begin
            $error("relative_width exp %0d got %0d", e.relw, relative_width);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_price(logic [23:0] price);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    close_price <= price;
    do @(posedge clk); while (!in_ready);
    pending_bands.insert(pending_bands.size(), predict_bands(price));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      win_len_cfg = val[5:0];
      clear_history();
    end else begin
      k_cfg = val[9:0];
    end
  endtask

  function automatic logic [23:0] rand_price(int mode);
    case (mode)
      0: return 24'($urandom_range(16777215));
      1: return 24'd1000 + 24'($urandom_range(63));
      2: return 24'($urandom_range(3));
      default: return $urandom_range(1) ? 24'hFFFFFF - 24'($urandom_range(255))
                                        : 24'($urandom_range(255));
    endcase
  endfunction

  task automatic test_directed();
    send_idle = 0; recv_stall = 0;
    write_reg(REG_WINDOW_LENGTH, 10'd2);
    send_price(24'd0); send_price(24'd0);       // zero mean, zero width
    send_price(24'hFFFFFF); send_price(24'd0);  // extremes
    send_price(24'hFFFFFF); send_price(24'hFFFFFF);
    write_reg(REG_BAND_MULTIPLIER, 10'd1023);
    send_price(24'd0); send_price(24'hFFFFFF); send_price(24'h555555);
    send_price(24'hAAAAAA); send_price(24'd1); send_price(24'd0);
    write_reg(REG_BAND_MULTIPLIER, 10'd0);
    send_price(24'd100); send_price(24'd5000);
    write_reg(REG_WINDOW_LENGTH, 10'd0);   // below range acts as two
    write_reg(REG_BAND_MULTIPLIER, 10'd256);
    send_price(24'd7); send_price(24'd9); send_price(24'd3);
    write_reg(REG_WINDOW_LENGTH, 10'd63);  // above range acts as 32
    for (int i = 0; i < 8; i++) send_price(rand_price(3));
  endtask

  task automatic test_random();
    int lens[6] = '{2, 3, 5, 20, 32, 17};
    int ks[6] = '{512, 1023, 0, 1, 300, 128};
    int idle_s[4] = '{0, 46, 0, 19};
    int idle_r[4] = '{0, 0, 46, 19};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WINDOW_LENGTH, CFG_W'(lens[ph]));
      write_reg(REG_BAND_MULTIPLIER, CFG_W'(ks[ph]));
      send_idle = idle_s[ph % 4];
      recv_stall = idle_r[ph % 4];
      for (int i = 0; i < 80; i++) begin
        send_price(rand_price($urandom_range(3)));
        if (i == 40) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    clear_history();
    test_directed();
    test_random();
    wait_drained();
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
